@@ rtl/core/sorted_deque_list_unit_macros.svh @@
// Assertion helpers for the sorted deque list unit.
`ifndef SORTED_DEQUE_LIST_UNIT_MACROS_SVH
`define SORTED_DEQUE_LIST_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SDL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sdl assertion failed");

// Next-cycle implication, quiet during reset.
`define SDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sdl assertion failed");

`endif

@@ rtl/core/sdl_pkg.sv @@
`default_nettype none

package sdl_pkg;

    localparam int SDL_CAPACITY = 16;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT    = 3'd0,
        FN_PUSH_BACK     = 3'd1,
        FN_INSERT_SORTED = 3'd2,
        FN_POP_FRONT     = 3'd3,
        FN_POP_BACK      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // What every cell does on a clock edge.
    typedef enum logic [2:0] {
        SH_HOLD,
        SH_FROM_LEFT,
        SH_AT_TAIL,
        SH_SORTED,
        SH_FROM_RIGHT
    } t_shift;

    typedef struct packed {
        t_shift             mode;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/core/sdl_cell.sv @@
`default_nettype none

module sdl_cell
    import sdl_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic signed [31:0] i_left_val,
    input  wire logic signed [31:0] i_right_val,
    input  wire logic               i_found,
    output logic                    o_found,
    input  wire logic signed [31:0] i_tail,
    output logic signed [31:0]      o_tail,
    output logic signed [31:0]      o_val
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX + 1);

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic               hit;

    // Any held entry greater than the new value, or the slot just past the tail.
    assign hit     = ((IDX_C < i_count) && (r_val > i_ctl.value)) || (IDX_C == i_count);
    assign o_found = i_found || hit;
    assign o_tail  = (IDX_N == i_count) ? r_val : i_tail;
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            SH_FROM_LEFT:  n_val = i_left_val;
            SH_AT_TAIL:    n_val = (IDX_C == i_count) ? i_ctl.value : r_val;
            SH_SORTED: begin
                if (i_found) begin
                    n_val = i_left_val;
                end else if (hit) begin
                    n_val = i_ctl.value;
                end
            end
            SH_FROM_RIGHT: n_val = i_right_val;
            default:       n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_deque_list_unit.sv @@
// An input transfer's result is registered in the output register.
// Throughput: one transfer per cycle unless a held result stalls the input;
// every cell updates in parallel, and the cycle is set by the ripple of the
// insert-position and tail-select chains that run through all CAPACITY cells.
// Reset (synchronous, active low) clears the entry count and the output valid;
// the entry cells are not reset and are only read below the count.
`default_nettype none

`include "sorted_deque_list_unit_macros.svh"

module sorted_deque_list_unit
    import sdl_pkg::*;
#(
    parameter int CAPACITY = SDL_CAPACITY
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [31:0] i_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_removed_value,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_count,
    output logic                    o_list_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Entry count and the chain wires between neighboring cells.
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic signed [31:0] cell_val [CAPACITY];
    logic               found    [CAPACITY+1];
    logic signed [31:0] tail     [CAPACITY+1];

    t_cell_ctl          cell_ctl;
    t_shift             mode;
    t_status            status;
    logic signed [31:0] removed;
    logic               in_xfer;
    logic               is_full;
    logic               is_empty;

    // Output register: the result waits here; the next item may enter as it drains.
    logic               r_out_valid;
    logic signed [31:0] r_removed;
    t_status            r_status;
    logic [CNT_W-1:0]   r_out_count;
    logic [31:0]        out_count_ext;

    // Accept whenever the output register is free or drains this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == CNT_FULL);
    assign is_empty   = (r_count == '0);

    // Decode the operation into one shift mode shared by every cell.
    // A refused push or pop, and an unused code, leave the cells on hold.
    always_comb begin
        mode    = SH_HOLD;
        status  = ST_OK;
        removed = '0;
        n_count = r_count;
        case (i_func)
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_SORTED: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (i_func == FN_PUSH_FRONT) begin
                        mode = SH_FROM_LEFT;
                    end else if (i_func == FN_PUSH_BACK) begin
                        mode = SH_AT_TAIL;
                    end else begin
                        mode = SH_SORTED;
                    end
                end
            end
            FN_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    mode    = SH_FROM_RIGHT;
                    removed = cell_val[0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            FN_POP_BACK: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    // Drop the tail: the count shrinks, the cells hold.
                    removed = tail[0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                mode = SH_HOLD;
            end
        endcase
        if (!in_xfer) begin
            mode    = SH_HOLD;
            n_count = r_count;
        end
    end

    assign cell_ctl.mode  = mode;
    assign cell_ctl.value = i_value;

    // Chain ends: nothing is found ahead of the front cell, and the tail
    // select starts empty behind the last cell.
    assign found[0]        = 1'b0;
    assign tail[CAPACITY]  = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [31:0] left_val;
        logic signed [31:0] right_val;

        // The front cell takes the new value on a push at the front.
        if (gi == 0) begin : g_front
            assign left_val = i_value;
        end else begin : g_mid_l
            assign left_val = cell_val[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_back
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[gi+1];
        end

        sdl_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_count     (r_count),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .i_found     (found[gi]),
            .o_found     (found[gi+1]),
            .i_tail      (tail[gi+1]),
            .o_tail      (tail[gi]),
            .o_val       (cell_val[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on each input transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_removed   <= removed;
            r_status    <= status;
            r_out_count <= n_count;
        end
    end

    // Report the low five bits of the count.
    assign out_count_ext   = 32'(r_out_count);
    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_entry_count   = out_count_ext[4:0];
    assign o_list_empty    = (r_out_count == '0);

    `SDL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `SDL_ASSERT_NEXT(a_xfer_gives_result, i_clk, i_rst_n, in_xfer, r_out_valid)
    `SDL_ASSERT_NEXT(a_full_refused, i_clk, i_rst_n,
        in_xfer && is_full && (i_func == FN_PUSH_FRONT || i_func == FN_PUSH_BACK
        || i_func == FN_INSERT_SORTED), (r_status == ST_FULL) && $stable(r_count))
    `SDL_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n,
        in_xfer && !is_empty && (i_func == FN_POP_FRONT || i_func == FN_POP_BACK),
        r_count == $past(r_count) - CNT_W'(1))

endmodule

`default_nettype wire
